/* rtl/tiled_2bpp_video_scanout_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tiled 2bpp scanout core
// Immediate-cycle and next-cycle checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TILED_2BPP_VIDEO_SCANOUT_CORE_MACROS_SVH
`define TILED_2BPP_VIDEO_SCANOUT_CORE_MACROS_SVH

// same-cycle implication
`define T2VS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define T2VS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/t2vs_pkg.sv */
// ----------------------------------------------------------------------------
// t2vs_pkg
// Shared types, constants and the color level table of the scanout core.
// ----------------------------------------------------------------------------
package t2vs_pkg;

  localparam int unsigned LINE_TOTAL_DEF  = 800;
  localparam int unsigned FRAME_LINES_DEF = 525;
  localparam int unsigned VRAM_DEPTH_DEF  = 65536;

  localparam logic [9:0] VIS_W = 10'd640;
  localparam logic [9:0] VIS_H = 10'd480;

  localparam int unsigned PAL_SEL_BIT = 4;

  typedef enum logic [4:0] {
    REG_DATA    = 5'd0,
    REG_ADDR_HI = 5'd1,
    REG_ADDR_LO = 5'd2
  } reg_code_t;

  typedef struct packed {
    logic        visible;
    logic [9:0]  col;
    logic [8:0]  row;
    logic        fetch;
    logic        use_last;
    logic [7:0]  last_byte;
    logic        odd;
    logic        frame_end;
    logic        buffer_sel;
    logic [31:0] frames;
  } tick_t;

  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } pal_wr_t;

  // 3-bit level * 255 / 7
  function automatic logic [7:0] level8(input logic [2:0] v);
    logic [7:0] r;
    case (v)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd36;
      3'd2:    r = 8'd72;
      3'd3:    r = 8'd109;
      3'd4:    r = 8'd145;
      3'd5:    r = 8'd182;
      3'd6:    r = 8'd218;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

endpackage

/* rtl/t2vs_vram.sv */
// ----------------------------------------------------------------------------
// t2vs_vram
// Video memory: one write port, one registered read port, zero sweep after
// reset.
// ----------------------------------------------------------------------------
module t2vs_vram #(
  parameter int unsigned DEPTH = t2vs_pkg::VRAM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clr_active;

endmodule

/* rtl/t2vs_front.sv */
// ----------------------------------------------------------------------------
// t2vs_front
// Beam counters, bus register decode, write pointer and contention tracking.
// Issues the VRAM fetch and hands each tick to the pixel stage.
// ----------------------------------------------------------------------------
module t2vs_front #(
  parameter int unsigned LINE_TOTAL  = t2vs_pkg::LINE_TOTAL_DEF,
  parameter int unsigned FRAME_LINES = t2vs_pkg::FRAME_LINES_DEF,
  parameter int unsigned VRAM_DEPTH  = t2vs_pkg::VRAM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(VRAM_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              cmd,
  input  logic [4:0]        reg_index,
  input  logic [7:0]        wdata,
  output logic              vram_we,
  output logic [AW-1:0]     vram_waddr,
  output logic [7:0]        vram_wdata,
  output logic              vram_re,
  output logic [AW-1:0]     vram_raddr,
  output logic              tick_go,
  output t2vs_pkg::tick_t   tick,
  output t2vs_pkg::pal_wr_t pal_wr
);

  localparam logic [16:0] DEPTH17 = 17'(VRAM_DEPTH);

  logic [9:0]  beam_col;
  logic [9:0]  beam_row;
  logic [7:0]  last_written;
  logic [1:0]  contention_count;
  logic [15:0] write_pointer;
  logic [31:0] frame_counter;
  logic        buffer_toggle;

  logic [9:0]  beam_col_next;
  logic [9:0]  beam_row_next;
  logic [31:0] frame_counter_next;
  logic        buffer_toggle_next;

  logic        bus_go;
  logic        visible;
  logic        fetch;
  logic        use_last;
  logic [10:0] col_inc;
  logic [10:0] row_inc;
  logic        line_end;
  logic        frame_wrap;
  logic [16:0] wp_ext;
  logic [16:0] wp_mod;
  logic [16:0] fa_ext;
  logic [16:0] fa_mod;

  assign bus_go  = go && cmd;
  assign tick_go = go && !cmd;

  assign visible  = (beam_col < t2vs_pkg::VIS_W) && (beam_row < t2vs_pkg::VIS_H);
  assign fetch    = visible && (beam_col[2:0] == 3'd0);
  assign use_last = (contention_count != 2'd0);

  // tiled layout: 8-row tiles, 1 KiB per tile row, 8 bytes per 8-pixel column
  assign wp_ext = {1'b0, write_pointer};
  assign wp_mod = (wp_ext >= DEPTH17) ? wp_ext - DEPTH17 : wp_ext;
  assign fa_ext = {1'b0, beam_row[9:4], beam_col[9:3], beam_row[3:1]};
  assign fa_mod = (fa_ext >= DEPTH17) ? fa_ext - DEPTH17 : fa_ext;

  assign col_inc    = {1'b0, beam_col} + 11'd1;
  assign row_inc    = {1'b0, beam_row} + 11'd1;
  assign line_end   = (col_inc >= 11'(LINE_TOTAL));
  assign frame_wrap = line_end && (row_inc >= 11'(FRAME_LINES));

  always_comb begin
    beam_col_next      = line_end ? 10'd0 : col_inc[9:0];
    beam_row_next      = beam_row;
    frame_counter_next = frame_counter;
    buffer_toggle_next = buffer_toggle;
    if (line_end) begin
      beam_row_next = frame_wrap ? 10'd0 : row_inc[9:0];
    end
    if (frame_wrap) begin
      frame_counter_next = frame_counter + 32'd1;
      buffer_toggle_next = ~buffer_toggle;
    end
  end

  always_comb begin
    tick.visible    = visible;
    tick.col        = visible ? beam_col : 10'd0;
    tick.row        = visible ? beam_row[8:0] : 9'd0;
    tick.fetch      = fetch;
    tick.use_last   = use_last;
    tick.last_byte  = last_written;
    tick.odd        = beam_col[0];
    tick.frame_end  = frame_wrap;
    tick.buffer_sel = buffer_toggle_next;
    tick.frames     = frame_counter_next;
  end

  assign vram_we    = bus_go && (reg_index == t2vs_pkg::REG_DATA);
  assign vram_waddr = wp_mod[AW-1:0];
  assign vram_wdata = wdata;
  assign vram_re    = tick_go && fetch && !use_last;
  assign vram_raddr = fa_mod[AW-1:0];

  assign pal_wr.en   = bus_go && reg_index[t2vs_pkg::PAL_SEL_BIT];
  assign pal_wr.idx  = reg_index[3:0];
  assign pal_wr.data = wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_col         <= '0;
      beam_row         <= '0;
      last_written     <= '0;
      contention_count <= '0;
      write_pointer    <= '0;
      frame_counter    <= '0;
      buffer_toggle    <= 1'b0;
    end else if (bus_go) begin
      if (reg_index == t2vs_pkg::REG_DATA) begin
        write_pointer    <= write_pointer + 16'd1;
        last_written     <= wdata;
        contention_count <= 2'd2;
      end else if (reg_index == t2vs_pkg::REG_ADDR_HI) begin
        write_pointer[15:8] <= wdata;
      end else if (reg_index == t2vs_pkg::REG_ADDR_LO) begin
        write_pointer[7:0] <= wdata;
      end
    end else if (tick_go) begin
      beam_col      <= beam_col_next;
      beam_row      <= beam_row_next;
      frame_counter <= frame_counter_next;
      buffer_toggle <= buffer_toggle_next;
      if (fetch && use_last) begin
        contention_count <= contention_count - 2'd1;
      end
    end
  end

endmodule

/* rtl/t2vs_pixel.sv */
// ----------------------------------------------------------------------------
// t2vs_pixel
// Pixel stage: shift register, palette lookup, RGBM expansion and the
// result register.
// ----------------------------------------------------------------------------
module t2vs_pixel (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_go,
  input  t2vs_pkg::tick_t   tick,
  input  logic [7:0]        rd_data,
  input  t2vs_pkg::pal_wr_t pal_wr,
  output logic              s1_free,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              pixel_valid,
  output logic [9:0]        pixel_col,
  output logic [8:0]        pixel_row,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              frame_end,
  output logic              buffer_sel,
  output logic [31:0]       frames_done
);

  logic [7:0]      palette [16];
  logic            s1_valid;
  t2vs_pkg::tick_t s1;
  logic [7:0]      shift_reg;

  logic            advance;
  logic [7:0]      base;
  logic [7:0]      shift_next;
  logic [7:0]      pal_byte;

  assign advance = !res_valid || res_ready;
  assign s1_free = !s1_valid || advance;

  always_comb begin
    if (s1.fetch) begin
      base = s1.use_last ? s1.last_byte : rd_data;
    end else begin
      base = shift_reg;
    end
    shift_next = s1.odd ? {base[5:0], 2'b00} : base;
    pal_byte   = palette[{2'b00, base[7:6]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      shift_reg <= '0;
      for (int i = 0; i < 16; i++) begin
        palette[i] <= '0;
      end
    end else begin
      if (pal_wr.en) begin
        palette[pal_wr.idx] <= pal_wr.data;
      end
      if (s1_free) begin
        s1_valid <= tick_go;
      end
      if (advance) begin
        res_valid <= s1_valid;
        if (s1_valid && s1.visible) begin
          shift_reg <= shift_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1 <= tick;
    end
    if (advance && s1_valid) begin
      pixel_valid <= s1.visible;
      pixel_col   <= s1.col;
      pixel_row   <= s1.row;
      if (s1.visible) begin
        red   <= t2vs_pkg::level8({pal_byte[7:6], pal_byte[0]});
        green <= t2vs_pkg::level8(pal_byte[5:3]);
        blue  <= t2vs_pkg::level8({pal_byte[2:1], pal_byte[0]});
      end else begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end
      frame_end   <= s1.frame_end;
      buffer_sel  <= s1.buffer_sel;
      frames_done <= s1.frames;
    end
  end

endmodule

/* rtl/tiled_2bpp_video_scanout_core.sv */
// ----------------------------------------------------------------------------
// tiled_2bpp_video_scanout_core
// Tiled 2bpp raster scanout with bus register port, palette and RGB output.
// ----------------------------------------------------------------------------
// Takes one request per cycle (a pixel tick or a bus register write) while
// the result side keeps up; each tick yields one result, bus writes yield
// none. Register update and VRAM read happen on acceptance; a tick then
// passes from the stage register through palette lookup into the result
// register, so only a stalled result holds the input back. After reset the
// VRAM is zeroed by a sweep over all VRAM_DEPTH addresses (65536 by
// default), during which req_ready is low.
module tiled_2bpp_video_scanout_core #(
  parameter int unsigned LINE_TOTAL  = t2vs_pkg::LINE_TOTAL_DEF,
  parameter int unsigned FRAME_LINES = t2vs_pkg::FRAME_LINES_DEF,
  parameter int unsigned VRAM_DEPTH  = t2vs_pkg::VRAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cmd,
  input  logic [4:0]  reg_index,
  input  logic [7:0]  wdata,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        pixel_valid,
  output logic [9:0]  pixel_col,
  output logic [8:0]  pixel_row,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        frame_end,
  output logic        buffer_sel,
  output logic [31:0] frames_done
);

  `include "tiled_2bpp_video_scanout_core_macros.svh"

  localparam int unsigned AW = $clog2(VRAM_DEPTH);

  logic              go;
  logic              busy;
  logic              s1_free;
  logic              vram_we;
  logic [AW-1:0]     vram_waddr;
  logic [7:0]        vram_wdata;
  logic              vram_re;
  logic [AW-1:0]     vram_raddr;
  logic [7:0]        vram_rdata;
  logic              tick_go;
  t2vs_pkg::tick_t   tick;
  t2vs_pkg::pal_wr_t pal_wr;

  assign req_ready = s1_free && !busy;
  assign go        = req_valid && req_ready;

  t2vs_front #(
    .LINE_TOTAL (LINE_TOTAL),
    .FRAME_LINES(FRAME_LINES),
    .VRAM_DEPTH (VRAM_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .cmd       (cmd),
    .reg_index (reg_index),
    .wdata     (wdata),
    .vram_we   (vram_we),
    .vram_waddr(vram_waddr),
    .vram_wdata(vram_wdata),
    .vram_re   (vram_re),
    .vram_raddr(vram_raddr),
    .tick_go   (tick_go),
    .tick      (tick),
    .pal_wr    (pal_wr)
  );

  t2vs_vram #(
    .DEPTH(VRAM_DEPTH)
  ) u_vram (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (vram_we),
    .wr_addr(vram_waddr),
    .wr_data(vram_wdata),
    .rd_en  (vram_re),
    .rd_addr(vram_raddr),
    .rd_data(vram_rdata),
    .busy   (busy)
  );

  t2vs_pixel u_pixel (
    .clk        (clk),
    .rst        (rst),
    .tick_go    (tick_go),
    .tick       (tick),
    .rd_data    (vram_rdata),
    .pal_wr     (pal_wr),
    .s1_free    (s1_free),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .pixel_valid(pixel_valid),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_end  (frame_end),
    .buffer_sel (buffer_sel),
    .frames_done(frames_done)
  );

  `T2VS_CHECK(a_frame_end_blank, res_valid && frame_end, !pixel_valid, "frame end on visible pixel")
  `T2VS_CHECK(a_pixel_in_area, res_valid && pixel_valid, (pixel_col < t2vs_pkg::VIS_W) && (pixel_row < t2vs_pkg::VIS_H[8:0]), "pixel outside visible area")
  `T2VS_CHECK(a_buf_parity, res_valid, buffer_sel == frames_done[0], "buffer select out of step with frame count")
  `T2VS_CHECK_NEXT(a_tick_result, go && !cmd, ##1 res_valid, "accepted tick produced no result")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tiled 2bpp scanout core. A queue of bus writes
// and pixel ticks feeds a valid/ready driver; a clocked monitor keeps its own
// raster, VRAM and palette image and checks every pixel result field by field.
// Runs three idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [4:0] REG_UNUSED_LO = 5'd3;
  localparam logic [4:0] REG_UNUSED_HI = 5'd15;
  localparam logic [4:0] REG_PALETTE0  = 5'd16;
  localparam logic [4:0] REG_PALETTE15 = 5'd31;

  typedef struct packed {
    logic       cmd;
    logic [4:0] reg_index;
    logic [7:0] wdata;
  } bus_req_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [9:0]  col;
    logic [8:0]  row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_end;
    logic        buffer_sel;
    logic [31:0] frames_done;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        cmd = CMD_TICK;
  logic [4:0]  reg_index = '0;
  logic [7:0]  wdata = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        pixel_valid;
  logic [9:0]  pixel_col;
  logic [8:0]  pixel_row;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        frame_end;
  logic        buffer_sel;
  logic [31:0] frames_done;

  // model of the core
  bit [7:0]    vram_model [0:t2vs_pkg::VRAM_DEPTH_DEF-1];
  bit [7:0]    palette_model [0:15];
  int unsigned beam_col;
  int unsigned beam_row;
  bit [7:0]    shifter;
  bit [7:0]    last_byte;
  bit [1:0]    contend_left;
  bit [15:0]   write_ptr;
  bit [31:0]   frame_count;
  bit          buffer_toggle;

  bus_req_t    pending_requests [$];
  pixel_t      expected_pixels [$];
  bus_req_t    next_req;
  bus_req_t    taken_req;
  pixel_t      want;
  bit          req_taken = 1'b0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 84;
  int unsigned mismatch_count = 0;
  int unsigned pixels_checked = 0;

  tiled_2bpp_video_scanout_core DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .cmd(cmd),
    .reg_index(reg_index),
    .wdata(wdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .pixel_valid(pixel_valid),
    .pixel_col(pixel_col),
    .pixel_row(pixel_row),
    .red(red),
    .green(green),
    .blue(blue),
    .frame_end(frame_end),
    .buffer_sel(buffer_sel),
    .frames_done(frames_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] rgb_level(input logic [2:0] v);
    return 8'((int'(v) * 255) / 7);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: pixel %0d: %s", $time, pixels_checked, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
    end
  endtask

  task automatic raster_step(input bus_req_t rq);
    pixel_t      px;
    int unsigned sr;
    int unsigned sc;
    bit [15:0]   addr;
    bit [1:0]    idx;
    bit [7:0]    pal;
    if (rq.cmd == CMD_WRITE) begin
      if (rq.reg_index == t2vs_pkg::REG_DATA) begin
        vram_model[write_ptr] = rq.wdata;
        write_ptr = write_ptr + 16'd1;
        last_byte = rq.wdata;
        contend_left = 2'd2;
      end else if (rq.reg_index == t2vs_pkg::REG_ADDR_HI) begin
        write_ptr[15:8] = rq.wdata;
      end else if (rq.reg_index == t2vs_pkg::REG_ADDR_LO) begin
        write_ptr[7:0] = rq.wdata;
      end else if (rq.reg_index[t2vs_pkg::PAL_SEL_BIT]) begin
        palette_model[rq.reg_index[3:0]] = rq.wdata;
      end
      return;
    end
    px = '0;
    if (beam_col < t2vs_pkg::VIS_W && beam_row < t2vs_pkg::VIS_H) begin
      sr = beam_row >> 1;
      sc = beam_col >> 1;
      if ((beam_col & 7) == 0) begin
        if (contend_left != 0) begin
          shifter = last_byte;
          contend_left = contend_left - 2'd1;
        end else begin
          addr = 16'((sr & 7) + ((sr >> 3) << 10) + ((sc >> 2) << 3));
          shifter = vram_model[addr];
        end
      end
      idx = shifter[7:6];
      if ((beam_col & 1) != 0) begin
        shifter = shifter << 2;
      end
      pal = palette_model[idx];
      px.pixel_valid = 1'b1;
      px.col = 10'(beam_col);
      px.row = 9'(beam_row);
      px.red = rgb_level({pal[7:6], pal[0]});
      px.green = rgb_level(pal[5:3]);
      px.blue = rgb_level({pal[2:1], pal[0]});
    end
    beam_col++;
    if (beam_col >= t2vs_pkg::LINE_TOTAL_DEF) begin
      beam_col = 0;
      beam_row++;
      if (beam_row >= t2vs_pkg::FRAME_LINES_DEF) begin
        beam_row = 0;
        frame_count = frame_count + 32'd1;
        buffer_toggle = ~buffer_toggle;
        px.frame_end = 1'b1;
      end
    end
    px.buffer_sel = buffer_toggle;
    px.frames_done = frame_count;
    expected_pixels.push_back(px);
  endtask

  task automatic queue_request(input logic c, input logic [4:0] r, input logic [7:0] d);
    bus_req_t rq;
    rq.cmd = c;
    rq.reg_index = r;
    rq.wdata = d;
    pending_requests.push_back(rq);
  endtask

  task automatic queue_tick();
    queue_request(CMD_TICK, 5'($urandom), 8'($urandom));
  endtask

  task automatic queue_mixed_traffic(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned burst;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_tick();
        n++;
      end else if (pick < 65) begin
        // pointer load followed by a short run of data writes
        queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_HI, 8'($urandom));
        queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_LO, 8'($urandom));
        burst = $urandom_range(1, 4);
        repeat (burst) queue_request(CMD_WRITE, t2vs_pkg::REG_DATA, 8'($urandom));
        n += burst + 2;
      end else if (pick < 75) begin
        queue_request(CMD_WRITE, t2vs_pkg::REG_DATA, 8'($urandom));
        n++;
      end else if (pick < 80) begin
        queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_HI, 8'($urandom));
        n++;
      end else if (pick < 85) begin
        queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_LO, 8'($urandom));
        n++;
      end else if (pick < 95) begin
        queue_request(CMD_WRITE, 5'($urandom_range(REG_PALETTE0, REG_PALETTE15)),
                      8'($urandom));
        n++;
      end else begin
        queue_request(CMD_WRITE, 5'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      8'($urandom));
        n++;
      end
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      if (!req_valid || req_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          req_valid <= 1'b1;
          cmd <= next_req.cmd;
          reg_index <= next_req.reg_index;
          wdata <= next_req.wdata;
        end else begin
          req_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no tick outstanding");
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_valid", 32'(pixel_valid), 32'(want.pixel_valid));
          compare_field("pixel_col", 32'(pixel_col), 32'(want.col));
          compare_field("pixel_row", 32'(pixel_row), 32'(want.row));
          compare_field("red", 32'(red), 32'(want.red));
          compare_field("green", 32'(green), 32'(want.green));
          compare_field("blue", 32'(blue), 32'(want.blue));
          compare_field("frame_end", 32'(frame_end), 32'(want.frame_end));
          compare_field("buffer_sel", 32'(buffer_sel), 32'(want.buffer_sel));
          compare_field("frames_done", frames_done, want.frames_done);
        end
        pixels_checked++;
      end
      if (req_valid && req_ready) begin
        taken_req.cmd = cmd;
        taken_req.reg_index = reg_index;
        taken_req.wdata = wdata;
        raster_step(taken_req);
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: palette extremes, unused registers, pointer wrap, contention
    queue_request(CMD_WRITE, REG_PALETTE0, 8'hff);
    queue_request(CMD_WRITE, REG_PALETTE0 | 5'd1, 8'h55);
    queue_request(CMD_WRITE, REG_PALETTE0 | 5'd2, 8'haa);
    queue_request(CMD_WRITE, REG_PALETTE0 | 5'd3, 8'h01);
    queue_request(CMD_WRITE, REG_PALETTE15, 8'h00);
    queue_request(CMD_WRITE, REG_UNUSED_LO, 8'hff);
    queue_request(CMD_WRITE, REG_UNUSED_HI, 8'h5a);
    queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_HI, 8'hff);
    queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_LO, 8'hff);
    queue_request(CMD_WRITE, t2vs_pkg::REG_DATA, 8'he4);
    queue_request(CMD_WRITE, t2vs_pkg::REG_DATA, 8'h1b);
    queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_HI, 8'h00);
    queue_request(CMD_WRITE, t2vs_pkg::REG_ADDR_LO, 8'h08);
    queue_request(CMD_WRITE, t2vs_pkg::REG_DATA, 8'h27);
    repeat (11) queue_tick();
    queue_mixed_traffic(640);
    wait_until_drained();

    @(posedge clk);
    send_idle_pct = 84;
    recv_idle_pct = 38;
    queue_mixed_traffic(640);
    wait_until_drained();

    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mixed_traffic(600);
    wait_until_drained();

    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* tiled_2bpp_video_scanout_core.f */
+incdir+rtl
rtl/t2vs_pkg.sv
rtl/t2vs_vram.sv
rtl/t2vs_front.sv
rtl/t2vs_pixel.sv
rtl/tiled_2bpp_video_scanout_core.sv
tb/testbench.sv
